/* rtl/hti_pkg.sv */
// ----------------------------------------------------------------------------
// hti_pkg
// Shared widths and defaults for the Hilbert tile index block.
// ----------------------------------------------------------------------------
package hti_pkg;

	localparam int ZOOM_W         = 8;
	localparam int COORD_W        = 32;
	localparam int TNUM_W         = 63;
	localparam int ZOOM_LIMIT_DEF = 31;

endpackage

/* rtl/hti_req_if.sv */
// ----------------------------------------------------------------------------
// hti_req_if
// Request channel: zoom level and tile column and row, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hti_req_if;
	import hti_pkg::*;

	logic               valid;
	logic               ready;
	logic [ZOOM_W-1:0]  zoom;
	logic [COORD_W-1:0] tile_x;
	logic [COORD_W-1:0] tile_y;

	modport source (output valid, output zoom, output tile_x, output tile_y, input ready);
	modport sink   (input valid, input zoom, input tile_x, input tile_y, output ready);

endinterface

/* rtl/hti_res_if.sv */
// ----------------------------------------------------------------------------
// hti_res_if
// Result channel: range flag and tile number, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hti_res_if;
	import hti_pkg::*;

	logic              valid;
	logic              ready;
	logic              valid_res;
	logic [TNUM_W-1:0] tile_number;

	modport source (output valid, output valid_res, output tile_number, input ready);
	modport sink   (input valid, input valid_res, input tile_number, output ready);

endinterface

/* rtl/hilbert_tile_index.sv */
// ----------------------------------------------------------------------------
// hilbert_tile_index
// Map tile number from zoom level and tile column/row along a Hilbert curve.
// ----------------------------------------------------------------------------
// The block turns a zoom level and a tile column and row into one tile
// number: the count of all tiles at lower zoom levels, (4^zoom-1)/3, plus the
// position of the tile along a Hilbert curve over the 2^zoom by 2^zoom grid.
// A zoom above ZOOM_LIMIT, or a column or row at or beyond 2^zoom, returns
// valid_res = 0 and tile_number = 0. The block takes one request per clock
// cycle while the output stage is free or its result is taken, and presents
// results in order. The six-stage register chain carries each request: it
// lands in the first stage at the edge that takes it and moves on through
// a range check stage, four stages that each walk about a quarter of the
// ZOOM_LIMIT bit levels, and a final stage that adds the pyramid offset.
// When the result is not taken, every stage holds and the request port drops
// ready, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hilbert_tile_index #(
	parameter int ZOOM_LIMIT = hti_pkg::ZOOM_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hti_req_if.sink   req,
	hti_res_if.source res
);
	import hti_pkg::*;

	localparam int MZ  = ZOOM_LIMIT;
	localparam int HW  = 2 * ZOOM_LIMIT;      // Hilbert index width
	localparam int LPS = (ZOOM_LIMIT + 3) / 4; // bit levels per stage

	// Coordinates still to walk and the Hilbert digits collected so far.
	typedef struct packed {
		logic [MZ-1:0] x;
		logic [MZ-1:0] y;
		logic [HW-1:0] h;
	} lvl_t;

	// Walk LPS bit levels downward from bit top. Each level writes the
	// quadrant digit {qx, qx^qy}; a bottom-row quadrant swaps the coordinates,
	// reflecting them first on the right side. Bits above the level are used
	// up already, so inverting the whole word is the same as the reflection.
	function automatic lvl_t run_levels(input lvl_t s_in, input int top);
		lvl_t          s;
		logic          qx;
		logic          qy;
		logic [MZ-1:0] t;
		int            b;
		s = s_in;
		for (int j = 0; j < LPS; j++) begin
			b = top - j;
			if (b >= 0) begin
				qx = s.x[b];
				qy = s.y[b];
				s.h[2*b+1] = qx;
				s.h[2*b]   = qx ^ qy;
				if (!qy) begin
					if (qx) begin
						s.x = ~s.x;
						s.y = ~s.y;
					end
					t   = s.x;
					s.x = s.y;
					s.y = t;
				end
			end
		end
		return s;
	endfunction

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic              vr_s1, vr_s2, vr_s3, vr_s4, vr_s5, vr_s6;

	// Pipeline control: every stage moves when the output stage is free
	// or its result is being taken.
	logic adv;
	assign adv       = !v_s6 || res.ready;
	assign req.ready = adv;

	// Stage 1: range check, pre-swap and pyramid offset.
	// The walk always covers ZOOM_LIMIT levels; the unused top levels see zero
	// bits and only swap, so pre-swap when their count is odd.
	logic          ok_c;
	logic          sw_c;
	logic [HW-1:0] off_c;
	lvl_t          lvl_c;

	always_comb begin
		ok_c = (req.zoom <= ZOOM_W'(ZOOM_LIMIT))
			&& ((req.tile_x >> req.zoom) == '0)
			&& ((req.tile_y >> req.zoom) == '0);
		sw_c = 1'(ZOOM_LIMIT % 2) ^ req.zoom[0];
		off_c = '0;
		for (int j = 0; j < MZ; j++) begin
			off_c[2*j] = (req.zoom > ZOOM_W'(j));
		end
		lvl_c.h = '0;
		if (sw_c) begin
			lvl_c.x = req.tile_y[MZ-1:0];
			lvl_c.y = req.tile_x[MZ-1:0];
		end else begin
			lvl_c.x = req.tile_x[MZ-1:0];
			lvl_c.y = req.tile_y[MZ-1:0];
		end
	end

	logic [HW-1:0]     off_s1, off_s2, off_s3, off_s4, off_s5;
	lvl_t              lvl_s1, lvl_s2, lvl_s3, lvl_s4, lvl_s5;
	logic [TNUM_W-1:0] tn_s6;
	logic [HW:0]       sum_c;

	assign sum_c = {1'b0, off_s5} + {1'b0, lvl_s5.h};

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Payload of every stage; hold while stalled.
	always_ff @(posedge clk) begin
		if (adv) begin
			vr_s1  <= ok_c;
			off_s1 <= off_c;
			lvl_s1 <= lvl_c;

			vr_s2  <= vr_s1;
			off_s2 <= off_s1;
			lvl_s2 <= run_levels(lvl_s1, MZ - 1);

			vr_s3  <= vr_s2;
			off_s3 <= off_s2;
			lvl_s3 <= run_levels(lvl_s2, MZ - 1 - LPS);

			vr_s4  <= vr_s3;
			off_s4 <= off_s3;
			lvl_s4 <= run_levels(lvl_s3, MZ - 1 - 2 * LPS);

			vr_s5  <= vr_s4;
			off_s5 <= off_s4;
			lvl_s5 <= run_levels(lvl_s4, MZ - 1 - 3 * LPS);

			vr_s6  <= vr_s5;
			tn_s6  <= vr_s5 ? TNUM_W'(sum_c) : '0;
		end
	end

	assign res.valid       = v_s6;
	assign res.valid_res   = vr_s6;
	assign res.tile_number = tn_s6;

	// A stalled stage keeps its item and its data.
	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s3) |=> (v_s3 && $stable(lvl_s3) && $stable(off_s3)))
		else $error("stage 3 changed while stalled");

	// An advancing last walk stage lands in the output stage.
	ap_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s5) |=> v_s6)
		else $error("item lost between stage 5 and output");

	// After the walk, the Hilbert index stays below 4^zoom = 3*offset + 1.
	ap_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && vr_s5) |-> ({1'b0, lvl_s5.h} <= ({off_s5, 1'b0} + {1'b0, off_s5})))
		else $error("Hilbert index beyond grid size");

	// An out-of-range request carries no Hilbert digits or offset bits that leak.
	ap_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s5 && !vr_s5) |=> (tn_s6 == '0))
		else $error("invalid request gave nonzero tile number");

endmodule
